[rtl/core/ihrl_pkg.sv]
// Shared types, codes and constants of the Intel HEX record loader.
// Used by every loader module except ihrl_ram; depends on nothing else.
package ihrl_pkg;

  localparam int unsigned MAX_DATA = 32;

  localparam logic CFG_FLASH_BASE = 1'b0;
  localparam logic CFG_FLASH_END  = 1'b1;

  localparam logic [23:0] FLASH_BASE_RST = 24'h800000;
  localparam logic [23:0] FLASH_END_RST  = 24'h87F000;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [2:0] ST_WRITTEN     = 3'd0;
  localparam logic [2:0] ST_END         = 3'd1;
  localparam logic [2:0] ST_OFFSET      = 3'd2;
  localparam logic [2:0] ST_TOO_LONG    = 3'd3;
  localparam logic [2:0] ST_CHECKSUM    = 3'd4;
  localparam logic [2:0] ST_RANGE       = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;
  localparam logic [2:0] ST_NOT_RECORD  = 3'd7;

  localparam logic [7:0] TYPE_DATA    = 8'd0;
  localparam logic [7:0] TYPE_EOF     = 8'd1;
  localparam logic [7:0] TYPE_SEGMENT = 8'd2;

  typedef enum logic [1:0] {
    JOB_REPORT,
    JOB_DATA,
    JOB_OFFSET
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [2:0]  status;
    logic [7:0]  count;
    logic [15:0] address;
    logic [8:0]  nvalid;
    logic        bank;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 4'(c - 8'h57);
    end
    return d;
  endfunction

endpackage

[rtl/core/ihrl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module ihrl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ihrl_job_fifo.sv]
// Two-entry queue of parsed record jobs between the parser and the executor.
// Depends on ihrl_pkg for the job type.
module ihrl_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ihrl_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output ihrl_pkg::job_t job_o
);
  import ihrl_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/ihrl_front.sv]
// Character parser: assembles the hex fields of one line, stores data bytes
// in a line buffer bank and queues one job per line. Depends on ihrl_pkg.
module ihrl_front #(
  parameter int unsigned MaxData = ihrl_pkg::MAX_DATA
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 char_code_i,
  input  logic                       line_end_i,
  input  logic                       push_i,
  output logic                       full_o,
  output logic                       job_push_o,
  output ihrl_pkg::job_t             job_o,
  input  logic                       fifo_full_i,
  input  ihrl_pkg::bank_rel_t        rel_i,
  output logic                       ram_we_o,
  output logic [$clog2(MaxData):0]   ram_waddr_o,
  output logic [7:0]                 ram_wdata_o
);
  import ihrl_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxData);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_RECORD = 2'd1;
  localparam logic [1:0] PH_OTHER  = 2'd2;

  localparam logic [1:0] FLD_COUNT = 2'd0;
  localparam logic [1:0] FLD_ADDR  = 2'd1;
  localparam logic [1:0] FLD_TYPE  = 2'd2;
  localparam logic [1:0] FLD_DATA  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic        skip_q, skip_d;
  logic        ended_q, ended_d;
  logic [1:0]  fidx_q, fidx_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [15:0] fval_q, fval_d;
  logic [7:0]  rcount_q, rcount_d;
  logic [15:0] raddr_q, raddr_d;
  logic [7:0]  rtype_q, rtype_d;
  logic [7:0]  sum_q, sum_d;
  logic [8:0]  didx_q, didx_d;
  logic        bank_q, bank_d;
  logic [1:0]  busy_q, busy_d;

  logic        accept;
  logic        do_commit;
  logic [15:0] cv;
  logic [15:0] v_new;
  logic [2:0]  dcnt_new;
  logic [2:0]  limit;
  job_t        job;

  assign full_o      = busy_q[bank_q] || fifo_full_i;
  assign accept      = push_i && !full_o;
  assign ram_waddr_o = {bank_q, didx_q[IdxW-1:0]};
  assign ram_wdata_o = cv[7:0];
  assign job_o       = job;

  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    ended_d    = ended_q;
    fidx_d     = fidx_q;
    dcnt_d     = dcnt_q;
    fval_d     = fval_q;
    rcount_d   = rcount_q;
    raddr_d    = raddr_q;
    rtype_d    = rtype_q;
    sum_d      = sum_q;
    didx_d     = didx_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    do_commit  = 1'b0;
    cv         = fval_q;
    ram_we_o   = 1'b0;
    job_push_o = 1'b0;
    job        = '0;
    v_new      = {fval_q[11:0], hex_digit(char_code_i)};
    dcnt_new   = dcnt_q + 3'd1;
    limit      = (fidx_q == FLD_ADDR) ? 3'd4 : 3'd2;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (accept && !line_end_i) begin
      if (phase_q == PH_START) begin
        phase_d = (char_code_i == CHAR_COLON) ? PH_RECORD : PH_OTHER;
      end else if (phase_q == PH_RECORD && !ended_q) begin
        if (!(skip_q && char_code_i == CHAR_SPACE)) begin
          skip_d = 1'b0;
          if (!(fidx_q == FLD_DATA && didx_q > {1'b0, rcount_q})) begin
            if (char_code_i == CHAR_SPACE) begin
              do_commit = 1'b1;
              ended_d   = 1'b1;
            end else if (dcnt_new >= limit) begin
              do_commit = 1'b1;
              cv        = v_new;
            end else begin
              fval_d = v_new;
              dcnt_d = dcnt_new;
            end
          end
        end
      end
    end

    if (accept && line_end_i && phase_q == PH_RECORD && !ended_q) begin
      do_commit = 1'b1;
    end

    if (do_commit) begin
      case (fidx_q)
        FLD_COUNT: begin
          rcount_d = cv[7:0];
          sum_d    = sum_q + cv[7:0];
          fidx_d   = FLD_ADDR;
        end
        FLD_ADDR: begin
          raddr_d = cv;
          sum_d   = sum_q + cv[7:0] + cv[15:8];
          fidx_d  = FLD_TYPE;
        end
        FLD_TYPE: begin
          rtype_d = cv[7:0];
          sum_d   = sum_q + cv[7:0];
          fidx_d  = FLD_DATA;
        end
        default: begin
          if (didx_q <= {1'b0, rcount_q}) begin
            ram_we_o = didx_q < 9'(MaxData);
            sum_d    = sum_q + cv[7:0];
            didx_d   = didx_q + 9'd1;
          end
        end
      endcase
      fval_d = '0;
      dcnt_d = '0;
    end

    if (accept && line_end_i) begin
      job.count   = rcount_d;
      job.address = raddr_d;
      job.nvalid  = didx_d;
      job.bank    = bank_q;
      job.kind    = JOB_REPORT;
      if (phase_q != PH_RECORD) begin
        job.status = ST_NOT_RECORD;
      end else if ({1'b0, rcount_d} > 9'(MaxData)) begin
        job.status = ST_TOO_LONG;
      end else if (sum_d != 8'd0) begin
        job.status = ST_CHECKSUM;
      end else if (rtype_d == TYPE_DATA) begin
        job.kind   = JOB_DATA;
        job.status = ST_WRITTEN;
      end else if (rtype_d == TYPE_EOF) begin
        job.status = ST_END;
      end else if (rtype_d == TYPE_SEGMENT && rcount_d == 8'd2) begin
        job.kind   = JOB_OFFSET;
        job.status = ST_OFFSET;
      end else begin
        job.status = ST_UNSUPPORTED;
      end
      job_push_o     = 1'b1;
      busy_d[bank_q] = 1'b1;
      bank_d         = ~bank_q;
      phase_d        = PH_START;
      skip_d         = 1'b1;
      ended_d        = 1'b0;
      fidx_d         = FLD_COUNT;
      dcnt_d         = '0;
      fval_d         = '0;
      rcount_d       = '0;
      raddr_d        = '0;
      rtype_d        = '0;
      sum_d          = '0;
      didx_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      skip_q   <= 1'b1;
      ended_q  <= 1'b0;
      fidx_q   <= FLD_COUNT;
      dcnt_q   <= '0;
      fval_q   <= '0;
      rcount_q <= '0;
      raddr_q  <= '0;
      rtype_q  <= '0;
      sum_q    <= '0;
      didx_q   <= '0;
      bank_q   <= 1'b0;
      busy_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      ended_q  <= ended_d;
      fidx_q   <= fidx_d;
      dcnt_q   <= dcnt_d;
      fval_q   <= fval_d;
      rcount_q <= rcount_d;
      raddr_q  <= raddr_d;
      rtype_q  <= rtype_d;
      sum_q    <= sum_d;
      didx_q   <= didx_d;
      bank_q   <= bank_d;
      busy_q   <= busy_d;
    end
  end

endmodule

[rtl/core/ihrl_back.sv]
// Record executor: takes queued jobs, computes flash targets, checks the
// range, emits byte writes and status results. Depends on ihrl_pkg.
module ihrl_back #(
  parameter int unsigned MaxData = ihrl_pkg::MAX_DATA
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  ihrl_pkg::job_t            job_i,
  output logic                      job_pop_o,
  input  logic [23:0]               flash_base_i,
  input  logic [23:0]               flash_end_i,
  output logic                      ram_re_o,
  output logic [$clog2(MaxData):0]  ram_raddr_o,
  input  logic [7:0]                ram_rdata_i,
  output ihrl_pkg::bank_rel_t       rel_o,
  output logic                      empty,
  input  logic                      pop,
  output logic [2:0]                status_o,
  output logic                      write_valid_o,
  output logic [23:0]               flash_address_o,
  output logic [7:0]                data_byte_o,
  output logic                      last_o
);
  import ihrl_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxData);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_REPORT  = 4'd1;
  localparam logic [3:0] S_BASE    = 4'd2;
  localparam logic [3:0] S_ADDR    = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_READ    = 4'd5;
  localparam logic [3:0] S_BYTE    = 4'd6;
  localparam logic [3:0] S_OFF_RD1 = 4'd7;
  localparam logic [3:0] S_OFF_SET = 4'd8;

  logic [3:0]  state_q, state_d;
  job_t        job_q, job_d;
  logic [2:0]  st_q, st_d;
  logic [24:0] target_q, target_d;
  logic [7:0]  idx_q, idx_d;
  logic [15:0] off_q, off_d;
  logic [7:0]  hi_q, hi_d;

  logic        ov_q, ov_d;
  logic [2:0]  ost_q, ost_d;
  logic        owv_q, owv_d;
  logic [23:0] oaddr_q, oaddr_d;
  logic [7:0]  odata_q, odata_d;
  logic        olast_q, olast_d;

  logic        out_free;
  logic        is_last;
  logic        byte_ok;

  assign out_free        = !ov_q || pop;
  assign is_last         = ({1'b0, idx_q} + 9'd1) == {1'b0, job_q.count};
  assign byte_ok         = {1'b0, idx_q} < job_q.nvalid;
  assign empty           = !ov_q;
  assign status_o        = ost_q;
  assign write_valid_o   = owv_q;
  assign flash_address_o = oaddr_q;
  assign data_byte_o     = odata_q;
  assign last_o          = olast_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    st_d        = st_q;
    target_d    = target_q;
    idx_d       = idx_q;
    off_d       = off_q;
    hi_d        = hi_q;
    ov_d        = (pop && ov_q) ? 1'b0 : ov_q;
    ost_d       = ost_q;
    owv_d       = owv_q;
    oaddr_d     = oaddr_q;
    odata_d     = odata_q;
    olast_d     = olast_q;
    job_pop_o   = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {job_q.bank, idx_q[IdxW-1:0]};
    rel_o       = '{valid: 1'b0, bank: job_q.bank};

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          st_d      = job_i.status;
          idx_d     = '0;
          unique case (job_i.kind)
            JOB_DATA: state_d = S_BASE;
            JOB_OFFSET: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = {job_i.bank, {IdxW{1'b0}}};
              state_d     = S_OFF_RD1;
            end
            default: state_d = S_REPORT;
          endcase
        end
      end
      S_REPORT: begin
        if (out_free) begin
          ov_d        = 1'b1;
          ost_d       = st_q;
          owv_d       = 1'b0;
          oaddr_d     = '0;
          odata_d     = '0;
          olast_d     = 1'b1;
          rel_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_BASE: begin
        target_d = {1'b0, flash_base_i} + {5'd0, off_q, 4'd0};
        state_d  = S_ADDR;
      end
      S_ADDR: begin
        target_d = target_q + {9'd0, job_q.address};
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if ((target_q + {17'd0, job_q.count}) > {1'b0, flash_end_i}) begin
          st_d    = ST_RANGE;
          state_d = S_REPORT;
        end else if (job_q.count == 8'd0) begin
          st_d    = ST_WRITTEN;
          state_d = S_REPORT;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
        state_d  = S_BYTE;
      end
      S_BYTE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ost_d    = ST_WRITTEN;
          owv_d    = 1'b1;
          oaddr_d  = target_q[23:0];
          odata_d  = byte_ok ? ram_rdata_i : 8'd0;
          olast_d  = is_last;
          target_d = target_q + 25'd1;
          idx_d    = idx_q + 8'd1;
          if (is_last) begin
            rel_o.valid = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_OFF_RD1: begin
        hi_d        = (job_q.nvalid != 9'd0) ? ram_rdata_i : 8'd0;
        ram_re_o    = 1'b1;
        ram_raddr_o = {job_q.bank, IdxW'(1)};
        state_d     = S_OFF_SET;
      end
      S_OFF_SET: begin
        off_d   = {hi_q, (job_q.nvalid > 9'd1) ? ram_rdata_i : 8'd0};
        state_d = S_REPORT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    st_q     <= st_d;
    target_q <= target_d;
    idx_q    <= idx_d;
    hi_q     <= hi_d;
    ost_q    <= ost_d;
    owv_q    <= owv_d;
    oaddr_q  <= oaddr_d;
    odata_q  <= odata_d;
    olast_q  <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      off_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
      ov_q    <= ov_d;
    end
  end

endmodule

[rtl/core/intel_hex_record_loader_core.sv]
// Intel HEX record loader top level: parser, job queue, executor, line RAM
// and the two flash window registers. Depends on ihrl_pkg and all ihrl_ modules.
//
// The parser accepts a character while full is low, and a line end queues the line
// as one job at the edge that accepts it. With the executor idle and the result register
// free, a status-only line goes straight to the report state, which loads its result; a
// type 2 record first reads its two offset bytes from the line RAM and sets the offset; a
// data record first forms its flash target from base, offset and address and checks the
// range, then reports if it fails the check or carries no bytes. Otherwise each write is
// a line RAM read, then a load of the result register, paced further by pop. Data bytes
// are held in a line RAM of two banks, one per line in flight, each MaxData bytes rounded
// up to a power of two, so full stays high while the bank the parser is filling still
// holds a line that has not been carried out, or while two jobs wait in the queue. No
// clearing pass is needed after reset.
module intel_hex_record_loader_core #(
  parameter int unsigned MaxData = ihrl_pkg::MAX_DATA
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic [7:0]  char_code_i,
  input  logic        line_end_i,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        write_valid_o,
  output logic [23:0] flash_address_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);
  import ihrl_pkg::*;

  localparam int unsigned RamDepth = 2 * (1 << $clog2(MaxData));
  localparam int unsigned RamAw    = $clog2(RamDepth);

  logic [23:0] flash_base_q;
  logic [23:0] flash_end_q;

  logic        job_push;
  job_t        job_in;
  job_t        job_out;
  logic        fifo_full;
  logic        job_valid;
  logic        job_pop;
  bank_rel_t   rel;
  logic        ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic        ram_re;
  logic [RamAw-1:0] ram_raddr;
  logic [7:0]  ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= FLASH_BASE_RST;
      flash_end_q  <= FLASH_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLASH_BASE: flash_base_q <= cfg_data_i;
        default:        flash_end_q  <= cfg_data_i;
      endcase
    end
  end

  ihrl_front #(
    .MaxData(MaxData)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .line_end_i  (line_end_i),
    .push_i      (push),
    .full_o      (full),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .fifo_full_i (fifo_full),
    .rel_i       (rel),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  ihrl_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (fifo_full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .job_o   (job_out)
  );

  ihrl_ram #(
    .Width(8),
    .Depth(RamDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ihrl_back #(
    .MaxData(MaxData)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job_out),
    .job_pop_o       (job_pop),
    .flash_base_i    (flash_base_q),
    .flash_end_i     (flash_end_q),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .rel_o           (rel),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .write_valid_o   (write_valid_o),
    .flash_address_o (flash_address_o),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o)
  );

endmodule
